>>> hdl/hrlp_pkg.sv
// shared types, character codes and result layout for the request line parser
package hrlp_pkg;

  // default wrap size of the byte offset counter
  localparam int BUF_SIZE_DEF = 8192;

  // offsets are reported in this many bits
  localparam int OFS_BITS = 13;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // character codes
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_SP         = 8'h20;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_0          = 8'h30;
  localparam logic [7:0] CH_1          = 8'h31;
  localparam logic [7:0] CH_9          = 8'h39;
  localparam logic [7:0] CH_A          = 8'h41;
  localparam logic [7:0] CH_D          = 8'h44;
  localparam logic [7:0] CH_E          = 8'h45;
  localparam logic [7:0] CH_G          = 8'h47;
  localparam logic [7:0] CH_H          = 8'h48;
  localparam logic [7:0] CH_O          = 8'h4F;
  localparam logic [7:0] CH_P          = 8'h50;
  localparam logic [7:0] CH_S          = 8'h53;
  localparam logic [7:0] CH_T          = 8'h54;
  localparam logic [7:0] CH_Z          = 8'h5A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  // result status codes
  localparam logic [1:0] STATUS_DONE        = 2'd0;
  localparam logic [1:0] STATUS_BAD_METHOD  = 2'd1;
  localparam logic [1:0] STATUS_BAD_REQUEST = 2'd2;

  // method codes
  localparam logic [1:0] METHOD_GET     = 2'd0;
  localparam logic [1:0] METHOD_POST    = 2'd1;
  localparam logic [1:0] METHOD_HEAD    = 2'd2;
  localparam logic [1:0] METHOD_UNKNOWN = 2'd3;

  // byte classification made by the front part
  typedef struct packed {
    logic       is_sp;
    logic       is_cr;
    logic       is_lf;
    logic       is_slash;
    logic       is_dot;
    logic       is_h;
    logic       is_t;
    logic       is_p;
    logic       is_digit;
    logic       is_nz_digit;
    logic       method_ok;
    logic [3:0] digit;
  } byte_class_t;

  // one queue entry: the byte, its class and its offsets
  typedef struct packed {
    logic [7:0]          data;
    byte_class_t         cls;
    logic [OFS_BITS-1:0] here;
    logic [OFS_BITS-1:0] next;
  } byte_entry_t;

  // result beat, last declared field (status) in the lowest bits
  typedef struct packed {
    logic [5:0]          pad;
    logic [OFS_BITS-1:0] next_offset;
    logic [7:0]          version_minor;
    logic [7:0]          version_major;
    logic [OFS_BITS-1:0] line_end_offset;
    logic [OFS_BITS-1:0] uri_end_offset;
    logic [OFS_BITS-1:0] uri_start_offset;
    logic [OFS_BITS-1:0] method_end_offset;
    logic [OFS_BITS-1:0] line_start_offset;
    logic [1:0]          method_code;
    logic [1:0]          status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

>>> hdl/http_request_line_parser.sv
// top level of the request line parser
//
// Usage: request bytes enter on the slave stream, one byte per beat in
// s_tdata. Each finished request line, or each line cut short by a bad
// byte, gives one beat on the master stream carrying status, method code,
// the recorded offsets, the version numbers and the offset after the line.
// Offsets count bytes from reset, wrap at BUF_SIZE and are given in 13 bits.
//
// Throughput: one byte per cycle while results are taken. The front
// classifies each byte and stamps its offset; a four-entry queue feeds the
// back state machine, which takes one byte a cycle whenever the result
// register is free or is being emptied.
// The byte that ends the line passes through the queue; the result register
// loads when that byte leaves the queue.
// Reset clears the offset counter, the queue and the parser to the start
// state; no result is pending after reset.
// When the receiver stalls, the pending result holds, the back stops, the
// queue fills and s_tready drops once it is full.
module http_request_line_parser #(
  parameter int BUF_SIZE = hrlp_pkg::BUF_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // data_byte
  input  logic [7:0]                    s_tdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // status, method_code, line_start_offset, method_end_offset,
  // uri_start_offset, uri_end_offset, line_end_offset, version_major,
  // version_minor, next_offset, zero fill
  output logic [hrlp_pkg::RESULT_W-1:0] m_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready
);

  hrlp_pkg::byte_entry_t front_entry;
  hrlp_pkg::byte_entry_t back_entry;
  hrlp_pkg::result_t     result;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic                  take;

  assign s_tready = !q_full;
  assign take     = s_tvalid && !q_full;
  assign m_tdata  = result;

  // byte classification and offsets
  hrlp_front #(
    .BUF_SIZE(BUF_SIZE)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .data (s_tdata),
    .take (take),
    .entry(front_entry)
  );

  // queue between front and back
  hrlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_entry(front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_entry (back_entry)
  );

  // parser state machine and result register
  hrlp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (back_entry),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_result(result)
  );

endmodule

>>> hdl/hrlp_front.sv
// front part: byte offset counter and byte classification
module hrlp_front #(
  parameter int BUF_SIZE = hrlp_pkg::BUF_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data,
  input  logic                 take,
  output hrlp_pkg::byte_entry_t entry
);

  localparam int OFS_W = $clog2(BUF_SIZE);
  localparam int EXT_W = OFS_W + hrlp_pkg::OFS_BITS;

  logic [OFS_W-1:0] offset;
  logic [OFS_W-1:0] offset_next;
  logic [EXT_W-1:0] here_ext;
  logic [EXT_W-1:0] next_ext;

  // wrapping offset of the next byte
  assign offset_next = (offset == OFS_W'(BUF_SIZE - 1)) ? '0 : offset + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (take) begin
      offset <= offset_next;
    end
  end

  // offsets masked to the reported width
  assign here_ext = {{hrlp_pkg::OFS_BITS{1'b0}}, offset};
  assign next_ext = {{hrlp_pkg::OFS_BITS{1'b0}}, offset_next};

  // classify the byte
  always_comb begin
    entry.data             = data;
    entry.here             = here_ext[hrlp_pkg::OFS_BITS-1:0];
    entry.next             = next_ext[hrlp_pkg::OFS_BITS-1:0];
    entry.cls.is_sp        = (data == hrlp_pkg::CH_SP);
    entry.cls.is_cr        = (data == hrlp_pkg::CH_CR);
    entry.cls.is_lf        = (data == hrlp_pkg::CH_LF);
    entry.cls.is_slash     = (data == hrlp_pkg::CH_SLASH);
    entry.cls.is_dot       = (data == hrlp_pkg::CH_DOT);
    entry.cls.is_h         = (data == hrlp_pkg::CH_H);
    entry.cls.is_t         = (data == hrlp_pkg::CH_T);
    entry.cls.is_p         = (data == hrlp_pkg::CH_P);
    entry.cls.is_digit     = (data >= hrlp_pkg::CH_0) && (data <= hrlp_pkg::CH_9);
    entry.cls.is_nz_digit  = (data >= hrlp_pkg::CH_1) && (data <= hrlp_pkg::CH_9);
    entry.cls.method_ok    = ((data >= hrlp_pkg::CH_A) && (data <= hrlp_pkg::CH_Z)) ||
                             (data == hrlp_pkg::CH_UNDERSCORE);
    entry.cls.digit        = data[3:0];
  end

endmodule

>>> hdl/hrlp_queue.sv
// short queue of classified bytes between front and back
module hrlp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hrlp_pkg::byte_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output hrlp_pkg::byte_entry_t pop_entry
);

  localparam int DEPTH = hrlp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  hrlp_pkg::byte_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == (PTR_W + 1)'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/hrlp_back.sv
// back part: request line state machine and result register
module hrlp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  hrlp_pkg::byte_entry_t q_entry,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output hrlp_pkg::result_t     m_result
);

  typedef enum logic [14:0] {
    ST_START   = 15'b000000000000001,
    ST_METHOD  = 15'b000000000000010,
    ST_SP_URI  = 15'b000000000000100,
    ST_URI     = 15'b000000000001000,
    ST_HTTP    = 15'b000000000010000,
    ST_H       = 15'b000000000100000,
    ST_HT      = 15'b000000001000000,
    ST_HTT     = 15'b000000010000000,
    ST_HTTP_SL = 15'b000000100000000,
    ST_MAJ1    = 15'b000001000000000,
    ST_MAJ     = 15'b000010000000000,
    ST_MIN1    = 15'b000100000000000,
    ST_MIN     = 15'b001000000000000,
    ST_SP_END  = 15'b010000000000000,
    ST_ALMOST  = 15'b100000000000000
  } parse_state_t;

  localparam int OW = hrlp_pkg::OFS_BITS;

  parse_state_t state, state_next;
  logic [7:0]    chars [4];
  logic [7:0]    chars_next [4];
  logic [2:0]    method_length, method_length_next;
  logic [1:0]    method_kind, method_kind_next;
  logic [OW-1:0] start_mark, start_mark_next;
  logic [OW-1:0] method_end_mark, method_end_mark_next;
  logic [OW-1:0] uri_start_mark, uri_start_mark_next;
  logic [OW-1:0] uri_end_mark, uri_end_mark_next;
  logic [OW-1:0] cr_mark, cr_mark_next;
  logic          cr_seen, cr_seen_next;
  logic [7:0]    major_acc, major_acc_next;
  logic [7:0]    minor_acc, minor_acc_next;
  logic          emit;
  hrlp_pkg::result_t res;
  hrlp_pkg::byte_class_t cls;

  // acc * 10 + digit, held at 255
  function automatic logic [7:0] sat_digit(input logic [7:0] acc, input logic [3:0] d);
    logic [11:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {8'b0, d};
    return (v > 12'd255) ? 8'hFF : v[7:0];
  endfunction

  // method classification from the stored characters
  function automatic logic [1:0] classify(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [7:0] c2, input logic [7:0] c3,
                                          input logic [2:0] len);
    logic [1:0] k;
    k = hrlp_pkg::METHOD_UNKNOWN;
    if (len == 3'd3 && c0 == hrlp_pkg::CH_G && c1 == hrlp_pkg::CH_E &&
        c2 == hrlp_pkg::CH_T) begin
      k = hrlp_pkg::METHOD_GET;
    end else if (len == 3'd4 && c0 == hrlp_pkg::CH_P && c1 == hrlp_pkg::CH_O &&
                 c2 == hrlp_pkg::CH_S && c3 == hrlp_pkg::CH_T) begin
      k = hrlp_pkg::METHOD_POST;
    end else if (len == 3'd4 && c0 == hrlp_pkg::CH_H && c1 == hrlp_pkg::CH_E &&
                 c2 == hrlp_pkg::CH_A && c3 == hrlp_pkg::CH_D) begin
      k = hrlp_pkg::METHOD_HEAD;
    end
    return k;
  endfunction

  // take a byte whenever the result register can hold what it may produce
  assign q_pop = q_valid && (!m_tvalid || m_tready);
  assign cls   = q_entry.cls;

  // next state and result of one byte
  always_comb begin
    logic err;
    logic done;
    logic [1:0] err_code;
    err                  = 1'b0;
    done                 = 1'b0;
    err_code             = hrlp_pkg::STATUS_BAD_REQUEST;
    state_next           = state;
    chars_next           = chars;
    method_length_next   = method_length;
    method_kind_next     = method_kind;
    start_mark_next      = start_mark;
    method_end_mark_next = method_end_mark;
    uri_start_mark_next  = uri_start_mark;
    uri_end_mark_next    = uri_end_mark;
    cr_mark_next         = cr_mark;
    cr_seen_next         = cr_seen;
    major_acc_next       = major_acc;
    minor_acc_next       = minor_acc;

    case (state)
      ST_METHOD: begin
        if (cls.is_sp) begin
          method_end_mark_next = q_entry.here;
          method_kind_next     = classify(chars[0], chars[1], chars[2], chars[3],
                                          method_length);
          state_next           = ST_SP_URI;
        end else if (!cls.method_ok) begin
          err      = 1'b1;
          err_code = hrlp_pkg::STATUS_BAD_METHOD;
        end else begin
          if (method_length < 3'd4) begin
            chars_next[method_length[1:0]] = q_entry.data;
          end
          if (method_length < 3'd7) begin
            method_length_next = method_length + 1'b1;
          end
        end
      end
      ST_SP_URI: begin
        if (cls.is_slash) begin
          uri_start_mark_next = q_entry.next;
          state_next          = ST_URI;
        end else if (!cls.is_sp) begin
          err = 1'b1;
        end
      end
      ST_URI: begin
        if (cls.is_sp) begin
          uri_end_mark_next = q_entry.here;
          state_next        = ST_HTTP;
        end
      end
      ST_HTTP: begin
        if (cls.is_h) begin
          state_next = ST_H;
        end else if (!cls.is_sp) begin
          err = 1'b1;
        end
      end
      ST_H: begin
        if (cls.is_t) state_next = ST_HT;
        else err = 1'b1;
      end
      ST_HT: begin
        if (cls.is_t) state_next = ST_HTT;
        else err = 1'b1;
      end
      ST_HTT: begin
        if (cls.is_p) state_next = ST_HTTP_SL;
        else err = 1'b1;
      end
      ST_HTTP_SL: begin
        if (cls.is_slash) state_next = ST_MAJ1;
        else err = 1'b1;
      end
      ST_MAJ1: begin
        if (cls.is_nz_digit) begin
          major_acc_next = {4'b0, cls.digit};
          state_next     = ST_MAJ;
        end else begin
          err = 1'b1;
        end
      end
      ST_MAJ: begin
        if (cls.is_dot) begin
          state_next = ST_MIN1;
        end else if (!cls.is_digit) begin
          err = 1'b1;
        end else begin
          major_acc_next = sat_digit(major_acc, cls.digit);
        end
      end
      ST_MIN1: begin
        if (cls.is_digit) begin
          minor_acc_next = {4'b0, cls.digit};
          state_next     = ST_MIN;
        end else begin
          err = 1'b1;
        end
      end
      ST_MIN, ST_SP_END: begin
        if (cls.is_cr) begin
          cr_mark_next = q_entry.here;
          cr_seen_next = 1'b1;
          state_next   = ST_ALMOST;
        end else if (cls.is_lf) begin
          done = 1'b1;
        end else if (cls.is_sp) begin
          state_next = ST_SP_END;
        end else if (state == ST_MIN && cls.is_digit) begin
          minor_acc_next = sat_digit(minor_acc, cls.digit);
        end else begin
          err = 1'b1;
        end
      end
      ST_ALMOST: begin
        if (cls.is_lf) done = 1'b1;
        else err = 1'b1;
      end
      default: begin
        // start: skip line breaks, open the method on its first character or flag a bad one
        start_mark_next = q_entry.here;
        if (!(cls.is_cr || cls.is_lf)) begin
          if (!cls.method_ok) begin
            err      = 1'b1;
            err_code = hrlp_pkg::STATUS_BAD_METHOD;
          end else begin
            chars_next[0]      = q_entry.data;
            method_length_next = 3'd1;
            state_next         = ST_METHOD;
          end
        end
      end
    endcase

    // result beat
    res             = '0;
    res.next_offset = q_entry.next;
    if (err) begin
      res.status      = err_code;
      res.method_code = hrlp_pkg::METHOD_UNKNOWN;
    end else begin
      res.status            = hrlp_pkg::STATUS_DONE;
      res.method_code       = method_kind;
      res.line_start_offset = start_mark;
      res.method_end_offset = method_end_mark;
      res.uri_start_offset  = uri_start_mark;
      res.uri_end_offset    = uri_end_mark;
      res.line_end_offset   = cr_seen ? cr_mark : q_entry.here;
      res.version_major     = major_acc;
      res.version_minor     = minor_acc;
    end

    // back to the start of a new line
    emit = err || done;
    if (emit) begin
      state_next         = ST_START;
      method_length_next = '0;
      chars_next[0]      = '0;
      chars_next[1]      = '0;
      chars_next[2]      = '0;
      chars_next[3]      = '0;
      cr_seen_next       = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_START;
      chars[0]        <= '0;
      chars[1]        <= '0;
      chars[2]        <= '0;
      chars[3]        <= '0;
      method_length   <= '0;
      method_kind     <= hrlp_pkg::METHOD_UNKNOWN;
      start_mark      <= '0;
      method_end_mark <= '0;
      uri_start_mark  <= '0;
      uri_end_mark    <= '0;
      cr_mark         <= '0;
      cr_seen         <= 1'b0;
      major_acc       <= '0;
      minor_acc       <= '0;
    end else if (q_pop) begin
      state           <= state_next;
      chars           <= chars_next;
      method_length   <= method_length_next;
      method_kind     <= method_kind_next;
      start_mark      <= start_mark_next;
      method_end_mark <= method_end_mark_next;
      uri_start_mark  <= uri_start_mark_next;
      uri_end_mark    <= uri_end_mark_next;
      cr_mark         <= cr_mark_next;
      cr_seen         <= cr_seen_next;
      major_acc       <= major_acc_next;
      minor_acc       <= minor_acc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      m_result <= res;
    end
  end

endmodule
